>>> rtl/core/cbrt_pkg.sv
// Shared widths, register codes, reset values and types of the color blob run tracker.
package cbrt_pkg;

  // field widths
  localparam int PIX_W      = 8;
  localparam int COL_W      = 10;
  localparam int RUN_W      = 11;
  localparam int AREA_W     = 21;
  localparam int WIN_W      = 9;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 21;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_HUE_CENTER     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HUE_HALFWIDTH  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SAT_CENTER     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SAT_HALFWIDTH  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_AREA_THRESHOLD = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_RUN_THRESHOLD  = 3'd5;

  // configuration reset values
  localparam logic signed [WIN_W-1:0] HUE_CENTER_RST    = 9'sd0;
  localparam logic [WIN_W-1:0]        HUE_HALFWIDTH_RST = 9'd20;
  localparam logic signed [WIN_W-1:0] SAT_CENTER_RST    = -9'sd51;
  localparam logic [WIN_W-1:0]        SAT_HALFWIDTH_RST = 9'd75;
  localparam logic [AREA_W-1:0]       AREA_THRESH_RST   = 21'd300;
  localparam logic [RUN_W-1:0]        RUN_THRESH_RST    = 11'd26;

  // divider widths: 765*255 needs 18 bits, r+g+b needs 10 bits
  localparam int DIVIDEND_W = 18;
  localparam int DIVISOR_W  = 10;
  localparam int DIV_CNT_W  = $clog2(DIVIDEND_W);

  localparam logic [5:0] HUE_SCALE = 6'd60;
  localparam logic [9:0] SAT_SCALE = 10'd765;

  // row tracking limits
  localparam logic [COL_W-1:0]  COL_LAST = 10'd1023;
  localparam logic [AREA_W-1:0] AREA_MAX = '1;
  localparam logic [RUN_W-1:0]  RUN_MAX  = '1;

  // classifier-to-tracker queue
  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic signed [WIN_W-1:0] hue_center;
    logic [WIN_W-1:0]        hue_half;
    logic signed [WIN_W-1:0] sat_center;
    logic [WIN_W-1:0]        sat_half;
  } win_cfg_t;

  typedef struct packed {
    logic [AREA_W-1:0] area_thr;
    logic [RUN_W-1:0]  run_thr;
  } thr_cfg_t;

  typedef struct packed {
    logic [PIX_W-1:0] blue;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] red;
    logic             row_end;
    logic             frame_end;
    logic             match;
  } item_t;

endpackage

>>> rtl/core/cbrt_if.sv
// Pixel request and result request channel interfaces.
interface cbrt_in_if;
  import cbrt_pkg::*;
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pix_blue;
  logic [PIX_W-1:0] pix_green;
  logic [PIX_W-1:0] pix_red;
  logic             row_end;
  logic             frame_end;

  modport source (output valid, pix_blue, pix_green, pix_red, row_end, frame_end,
                  input ready);
  modport sink (input valid, pix_blue, pix_green, pix_red, row_end, frame_end,
                output ready);
endinterface

interface cbrt_out_if;
  import cbrt_pkg::*;
  logic              valid;
  logic              ready;
  logic [PIX_W-1:0]  out_blue;
  logic [PIX_W-1:0]  out_green;
  logic [PIX_W-1:0]  out_red;
  logic              is_match;
  logic              frame_done;
  logic              ball_found;
  logic [COL_W-1:0]  ball_x;
  logic [AREA_W-1:0] match_area;
  logic [RUN_W-1:0]  longest_run;
  logic [RUN_W-1:0]  row_width;

  modport source (output valid, out_blue, out_green, out_red, is_match, frame_done,
                  ball_found, ball_x, match_area, longest_run, row_width,
                  input ready);
  modport sink (input valid, out_blue, out_green, out_red, is_match, frame_done,
                ball_found, ball_x, match_area, longest_run, row_width,
                output ready);
endinterface

>>> rtl/core/cbrt_div.sv
// Restoring divider, one quotient bit per cycle.
module cbrt_div (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic [cbrt_pkg::DIVIDEND_W-1:0] dividend,
  input  logic [cbrt_pkg::DIVISOR_W-1:0]  divisor,
  output logic                            busy,
  output logic [cbrt_pkg::DIVIDEND_W-1:0] quotient
);
  import cbrt_pkg::*;

  logic                  busy_r;
  logic [DIV_CNT_W-1:0]  cnt_r;
  logic [DIVISOR_W-1:0]  rem_r;
  logic [DIVISOR_W-1:0]  rem_nxt;
  logic [DIVISOR_W-1:0]  dvs_r;
  logic [DIVIDEND_W-1:0] quo_r;
  logic [DIVISOR_W:0]    trial;
  logic                  take;

  // trial subtract of the next dividend bit
  always_comb begin
    trial   = {rem_r, quo_r[DIVIDEND_W-1]};
    take    = (trial >= {1'b0, dvs_r});
    rem_nxt = take ? DIVISOR_W'(trial - {1'b0, dvs_r}) : trial[DIVISOR_W-1:0];
  end

  // step control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 1'b1;
      if (cnt_r == DIV_CNT_W'(DIVIDEND_W - 1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  // shift remainder and quotient
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      dvs_r <= divisor;
      quo_r <= dividend;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= {quo_r[DIVIDEND_W-2:0], take};
    end
  end

  assign busy     = busy_r;
  assign quotient = quo_r;

endmodule

>>> rtl/core/cbrt_front.sv
// Pixel classifier: hue and saturation through two dividers, then window match.
module cbrt_front (
  input  logic               clk,
  input  logic               rst_n,
  cbrt_in_if.sink            in_pix,
  input  cbrt_pkg::win_cfg_t win,
  output logic               push_valid,
  input  logic               push_ready,
  output cbrt_pkg::item_t    push_item
);
  import cbrt_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_PREP = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;
  localparam logic [1:0] S_PUSH = 2'd3;

  localparam logic [1:0] SEC_RED   = 2'd0;
  localparam logic [1:0] SEC_GREEN = 2'd1;
  localparam logic [1:0] SEC_BLUE  = 2'd2;

  logic [1:0]       state_r;
  logic [1:0]       state_nxt;
  logic [PIX_W-1:0] blue_r;
  logic [PIX_W-1:0] green_r;
  logic [PIX_W-1:0] red_r;
  logic             row_end_r;
  logic             frame_end_r;
  logic             hue_neg_r;
  logic [1:0]       hue_sec_r;
  logic             grey_r;
  logic             sum_zero_r;

  logic             red_max;
  logic             green_max;
  logic [1:0]       hue_sec;
  logic [PIX_W-1:0] mx;
  logic [PIX_W-1:0] mn;
  logic [PIX_W-1:0] delta;
  logic [PIX_W:0]   diff;
  logic [PIX_W:0]   diff_abs;
  logic [13:0]      hue_num;
  logic [DIVIDEND_W-1:0] sat_num;
  logic [DIVISOR_W-1:0]  sum;
  logic                  div_start;
  logic                  hue_busy;
  logic                  sat_busy;
  logic [DIVIDEND_W-1:0] hue_quo;
  logic [DIVIDEND_W-1:0] sat_quo;

  logic signed [9:0]  hue_abs;
  logic signed [9:0]  hue_part;
  logic signed [9:0]  hue_ofs;
  logic signed [9:0]  hue_val;
  logic signed [9:0]  sat_val;
  logic signed [10:0] hue_lo;
  logic signed [10:0] hue_hi;
  logic signed [10:0] sat_lo;
  logic signed [10:0] sat_hi;
  logic               match;

  // pick the max channel with red, green, blue priority
  always_comb begin
    red_max   = (red_r >= green_r) && (red_r >= blue_r);
    green_max = !red_max && (green_r >= blue_r);
    if (red_max) begin
      hue_sec = SEC_RED;
      mx      = red_r;
      diff    = {1'b0, green_r} - {1'b0, blue_r};
    end else if (green_max) begin
      hue_sec = SEC_GREEN;
      mx      = green_r;
      diff    = {1'b0, blue_r} - {1'b0, red_r};
    end else begin
      hue_sec = SEC_BLUE;
      mx      = blue_r;
      diff    = {1'b0, red_r} - {1'b0, green_r};
    end
    mn = red_r;
    if (green_r < mn) mn = green_r;
    if (blue_r < mn) mn = blue_r;
    delta    = mx - mn;
    diff_abs = diff[PIX_W] ? (~diff + 1'b1) : diff;
    hue_num  = 14'(diff_abs[PIX_W-1:0]) * 14'(HUE_SCALE);
    sat_num  = DIVIDEND_W'(mn) * DIVIDEND_W'(SAT_SCALE);
    sum      = DIVISOR_W'(red_r) + DIVISOR_W'(green_r) + DIVISOR_W'(blue_r);
  end

  assign div_start = (state_r == S_PREP);

  cbrt_div u_hue_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (DIVIDEND_W'(hue_num)),
    .divisor  (DIVISOR_W'(delta)),
    .busy     (hue_busy),
    .quotient (hue_quo)
  );

  cbrt_div u_sat_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (sat_num),
    .divisor  (sum),
    .busy     (sat_busy),
    .quotient (sat_quo)
  );

  // finish hue and saturation, compare against the windows
  always_comb begin
    hue_abs  = $signed({3'b000, hue_quo[6:0]});
    hue_part = hue_neg_r ? -hue_abs : hue_abs;
    unique case (hue_sec_r)
      SEC_RED:   hue_ofs = 10'sd0;
      SEC_GREEN: hue_ofs = 10'sd120;
      SEC_BLUE:  hue_ofs = -10'sd120;
      default:   hue_ofs = 10'sd0;
    endcase
    hue_val = grey_r ? 10'sd0 : (hue_ofs + hue_part);
    sat_val = sum_zero_r ? 10'sd0 : (10'sd255 - $signed({2'b00, sat_quo[7:0]}));
    hue_lo  = $signed({{2{win.hue_center[WIN_W-1]}}, win.hue_center})
              - $signed({2'b00, win.hue_half});
    hue_hi  = $signed({{2{win.hue_center[WIN_W-1]}}, win.hue_center})
              + $signed({2'b00, win.hue_half});
    sat_lo  = $signed({{2{win.sat_center[WIN_W-1]}}, win.sat_center})
              - $signed({2'b00, win.sat_half});
    sat_hi  = $signed({{2{win.sat_center[WIN_W-1]}}, win.sat_center})
              + $signed({2'b00, win.sat_half});
    match   = ($signed({hue_val[9], hue_val}) > hue_lo)
              && ($signed({hue_val[9], hue_val}) < hue_hi)
              && ($signed({sat_val[9], sat_val}) > sat_lo)
              && ($signed({sat_val[9], sat_val}) < sat_hi);
  end

  // sequence one pixel at a time
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_pix.valid) state_nxt = S_PREP;
      S_PREP:  state_nxt = S_DIV;
      S_DIV:   if (!hue_busy && !sat_busy) state_nxt = S_PUSH;
      S_PUSH:  if (push_ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // capture the pixel request, then the divider setup
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_pix.valid) begin
      blue_r      <= in_pix.pix_blue;
      green_r     <= in_pix.pix_green;
      red_r       <= in_pix.pix_red;
      row_end_r   <= in_pix.row_end;
      frame_end_r <= in_pix.frame_end;
    end
    if (state_r == S_PREP) begin
      hue_neg_r  <= diff[PIX_W];
      hue_sec_r  <= hue_sec;
      grey_r     <= (delta == '0);
      sum_zero_r <= (sum == '0);
    end
  end

  assign in_pix.ready = (state_r == S_IDLE);
  assign push_valid   = (state_r == S_PUSH);

  always_comb begin
    push_item.blue      = blue_r;
    push_item.green     = green_r;
    push_item.red       = red_r;
    push_item.row_end   = row_end_r;
    push_item.frame_end = frame_end_r;
    push_item.match     = match;
  end

endmodule

>>> rtl/core/cbrt_queue.sv
// Small FIFO between the classifier and the run tracker.
module cbrt_queue #(
  parameter int DEPTH = cbrt_pkg::QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push_valid,
  output logic            push_ready,
  input  cbrt_pkg::item_t push_item,
  output logic            pop_valid,
  input  logic            pop_ready,
  output cbrt_pkg::item_t pop_item
);
  import cbrt_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  item_t            mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             push_fire;
  logic             pop_fire;

  assign push_ready = (count_r != CNT_W'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign push_fire  = push_valid && push_ready;
  assign pop_fire   = pop_valid && pop_ready;
  assign pop_item   = mem_r[rd_ptr_r];

  // store incoming request
  always_ff @(posedge clk) begin
    if (push_fire) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  // advance pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push_fire) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop_fire) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push_fire && !pop_fire) begin
        count_r <= count_r + 1'b1;
      end else if (pop_fire && !push_fire) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("queue fill count above depth");

  a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (push_fire && !pop_fire) |=> (count_r == CNT_W'($past(count_r) + 1'b1)))
    else $error("queue count did not grow on push");

  a_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0) |-> (wr_ptr_r == rd_ptr_r))
    else $error("empty queue with pointers apart");
`endif

endmodule

>>> rtl/core/cbrt_back.sv
// Run tracker: area count, longest run, frame summary and the output register.
module cbrt_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               pop_valid,
  output logic               pop_ready,
  input  cbrt_pkg::item_t    pop_item,
  input  cbrt_pkg::thr_cfg_t thr,
  cbrt_out_if.source         out_res
);
  import cbrt_pkg::*;

  logic [COL_W-1:0]  column_r,      column_nxt;
  logic [RUN_W-1:0]  run_len_r,     run_len_nxt;
  logic [COL_W-1:0]  run_start_r,   run_start_nxt;
  logic [RUN_W-1:0]  best_run_r,    best_run_nxt;
  logic [COL_W-1:0]  best_center_r, best_center_nxt;
  logic [AREA_W-1:0] area_r,        area_nxt;

  logic [COL_W:0]    span;
  logic [RUN_W-1:0]  width_now;
  logic [AREA_W-1:0] sum_area;
  logic [RUN_W-1:0]  sum_run;
  logic [COL_W-1:0]  sum_center;
  logic              found;
  logic              take;

  logic              out_valid_r;
  logic [PIX_W-1:0]  out_blue_r;
  logic [PIX_W-1:0]  out_green_r;
  logic [PIX_W-1:0]  out_red_r;
  logic              is_match_r;
  logic              frame_done_r;
  logic              ball_found_r;
  logic [COL_W-1:0]  ball_x_r;
  logic [AREA_W-1:0] match_area_r;
  logic [RUN_W-1:0]  longest_run_r;
  logic [RUN_W-1:0]  row_width_r;

  assign pop_ready = !out_valid_r || out_res.ready;
  assign take      = pop_valid && pop_ready;

  // update run statistics for one pixel
  always_comb begin
    area_nxt        = area_r;
    run_len_nxt     = run_len_r;
    run_start_nxt   = run_start_r;
    best_run_nxt    = best_run_r;
    best_center_nxt = best_center_r;
    column_nxt      = column_r;
    span            = {1'b0, column_r} - {1'b0, run_start_r};
    width_now       = {1'b0, column_r} + 1'b1;

    if (pop_item.match) begin
      if (area_r != AREA_MAX) area_nxt = area_r + 1'b1;
      if (run_len_r == '0) run_start_nxt = column_r;
      if (run_len_r != RUN_MAX) run_len_nxt = run_len_r + 1'b1;
    end else begin
      // close the open run
      if (run_len_r > best_run_r) begin
        best_center_nxt = run_start_r + span[COL_W:1];
        best_run_nxt    = run_len_r;
      end
      run_len_nxt = '0;
    end

    sum_area   = area_nxt;
    sum_run    = best_run_nxt;
    sum_center = best_center_nxt;
    found      = (area_nxt > thr.area_thr) && (best_run_nxt > thr.run_thr);

    // drop an open run at row or frame end, hold column at the last position
    if (pop_item.row_end || pop_item.frame_end) begin
      run_len_nxt = '0;
      column_nxt  = '0;
    end else if (column_r < COL_LAST) begin
      column_nxt = column_r + 1'b1;
    end

    // clear statistics after the summary
    if (pop_item.frame_end) begin
      run_len_nxt     = '0;
      run_start_nxt   = '0;
      best_run_nxt    = '0;
      best_center_nxt = '0;
      area_nxt        = '0;
      column_nxt      = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      column_r      <= '0;
      run_len_r     <= '0;
      run_start_r   <= '0;
      best_run_r    <= '0;
      best_center_r <= '0;
      area_r        <= '0;
    end else if (take) begin
      column_r      <= column_nxt;
      run_len_r     <= run_len_nxt;
      run_start_r   <= run_start_nxt;
      best_run_r    <= best_run_nxt;
      best_center_r <= best_center_nxt;
      area_r        <= area_nxt;
    end
  end

  // hold the result until the sink takes it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (take) begin
      out_valid_r <= 1'b1;
    end else if (out_res.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_blue_r    <= {1'b0, pop_item.blue[PIX_W-1:1]};
      out_green_r   <= {1'b0, pop_item.green[PIX_W-1:1]};
      out_red_r     <= pop_item.match ? '1 : {1'b0, pop_item.red[PIX_W-1:1]};
      is_match_r    <= pop_item.match;
      frame_done_r  <= pop_item.frame_end;
      ball_found_r  <= pop_item.frame_end && found;
      ball_x_r      <= pop_item.frame_end ? sum_center : '0;
      match_area_r  <= pop_item.frame_end ? sum_area : '0;
      longest_run_r <= pop_item.frame_end ? sum_run : '0;
      row_width_r   <= pop_item.frame_end ? width_now : '0;
    end
  end

  assign out_res.valid       = out_valid_r;
  assign out_res.out_blue    = out_blue_r;
  assign out_res.out_green   = out_green_r;
  assign out_res.out_red     = out_red_r;
  assign out_res.is_match    = is_match_r;
  assign out_res.frame_done  = frame_done_r;
  assign out_res.ball_found  = ball_found_r;
  assign out_res.ball_x      = ball_x_r;
  assign out_res.match_area  = match_area_r;
  assign out_res.longest_run = longest_run_r;
  assign out_res.row_width   = row_width_r;

endmodule

>>> rtl/core/color_blob_run_tracker.sv
// Top level: configuration registers, pixel classifier, queue and run tracker.
// Throughput: a new pixel is accepted only after the last one is written to the queue,
//   set by the two 18-step restoring dividers (accept, divider setup, 18 divide steps,
//   a check of the dividers, the queue write); a full queue holds the classifier.
// Path: classifier, queue, output register; only result sink stalls hold results back.
// Reset (synchronous, rst_n low): registers return to their defaults, statistics
//   clear and the queue empties; no clearing pass is needed.
module color_blob_run_tracker #(
  parameter int QUEUE_DEPTH = cbrt_pkg::QUEUE_DEPTH
) (
  input  logic                            clk,
  input  logic                            rst_n,
  cbrt_in_if.sink                         in_pix,
  cbrt_out_if.source                      out_res,
  input  logic                            cfg_we,
  input  logic [cbrt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cbrt_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import cbrt_pkg::*;

  win_cfg_t win_r;
  thr_cfg_t thr_r;
  logic     push_valid;
  logic     push_ready;
  item_t    push_item;
  logic     pop_valid;
  logic     pop_ready;
  item_t    pop_item;

  // write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r.hue_center <= HUE_CENTER_RST;
      win_r.hue_half   <= HUE_HALFWIDTH_RST;
      win_r.sat_center <= SAT_CENTER_RST;
      win_r.sat_half   <= SAT_HALFWIDTH_RST;
      thr_r.area_thr   <= AREA_THRESH_RST;
      thr_r.run_thr    <= RUN_THRESH_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_HUE_CENTER:     win_r.hue_center <= $signed(cfg_wdata[WIN_W-1:0]);
        CFG_HUE_HALFWIDTH:  win_r.hue_half   <= cfg_wdata[WIN_W-1:0];
        CFG_SAT_CENTER:     win_r.sat_center <= $signed(cfg_wdata[WIN_W-1:0]);
        CFG_SAT_HALFWIDTH:  win_r.sat_half   <= cfg_wdata[WIN_W-1:0];
        CFG_AREA_THRESHOLD: thr_r.area_thr   <= cfg_wdata[AREA_W-1:0];
        CFG_RUN_THRESHOLD:  thr_r.run_thr    <= cfg_wdata[RUN_W-1:0];
        default: ;
      endcase
    end
  end

  cbrt_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_pix     (in_pix),
    .win        (win_r),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item)
  );

  cbrt_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  cbrt_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_item  (pop_item),
    .thr       (thr_r),
    .out_res   (out_res)
  );

endmodule

>>> tb/tb.sv
// Self-checking testbench for the color blob run tracker: random-idle pixel stream, predicted marks and frame summaries.
module tb;
  import cbrt_pkg::*;

  localparam int CYCLE_LIMIT     = 3_000_000;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int RANDOM_ITEMS    = 250;
  localparam int SETTLE_CYCLES   = 60;
  localparam int LONG_ROW_PIXELS = 40;
  localparam int MAX_REPORTS     = 40;

  typedef struct packed {
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
    logic             row_end;
    logic             frame_end;
  } pixel_t;

  typedef struct packed {
    logic [PIX_W-1:0]  blue;
    logic [PIX_W-1:0]  green;
    logic [PIX_W-1:0]  red;
    logic              hit;
    logic              done;
    logic              found;
    logic [COL_W-1:0]  x;
    logic [AREA_W-1:0] area;
    logic [RUN_W-1:0]  run;
    logic [RUN_W-1:0]  width;
  } marked_pixel_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  cbrt_in_if  in_if ();
  cbrt_out_if out_if ();

  color_blob_run_tracker u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_pix    (in_if),
    .out_res   (out_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  pixel_t        pixels_pending[$];
  marked_pixel_t marks_due[$];
  int            pixels_queued;
  int            pixels_taken;
  int            mismatches;
  int            cycles;
  bit            pix_taken;
  bit            sender_steady;
  bit            receiver_steady;
  int            send_gap;
  int            stall_left;
  int            hold_left;
  int            hold_asks;
  int            hold_served;

  // predicted window settings and frame statistics
  int                hue_ctr;
  int                hue_half;
  int                sat_ctr;
  int                sat_half;
  logic [AREA_W-1:0] area_gate;
  logic [RUN_W-1:0]  run_min;
  logic [COL_W-1:0]  col;
  logic [COL_W-1:0]  run_beg;
  logic [COL_W-1:0]  best_mid;
  logic [RUN_W-1:0]  run_len;
  logic [RUN_W-1:0]  best_len;
  logic [AREA_W-1:0] area_cnt;

  function automatic int pixel_hue(int r, int g, int b);
    int mx;
    int mn;
    int d;
    mx = r;
    mn = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    d = mx - mn;
    if (d == 0) return 0;
    if (r == mx) return (60 * (g - b)) / d;
    if (g == mx) return 120 + (60 * (b - r)) / d;
    return -120 + (60 * (r - g)) / d;
  endfunction

  function automatic int pixel_saturation(int r, int g, int b);
    int mn;
    int sum;
    mn = r;
    sum = r + g + b;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    if (sum == 0) return 0;
    return 255 - (765 * mn) / sum;
  endfunction

  function automatic bit in_window(int r, int g, int b);
    int hue;
    int sat;
    hue = pixel_hue(r, g, b);
    sat = pixel_saturation(r, g, b);
    return hue > hue_ctr - hue_half && hue < hue_ctr + hue_half &&
           sat > sat_ctr - sat_half && sat < sat_ctr + sat_half;
  endfunction

  // clear statistics, restore default windows
  task automatic reset_tracker_model();
    hue_ctr   = 0;
    hue_half  = 20;
    sat_ctr   = -51;
    sat_half  = 75;
    area_gate = AREA_W'(300);
    run_min   = RUN_W'(26);
    col       = '0;
    run_beg   = '0;
    best_mid  = '0;
    run_len   = '0;
    best_len  = '0;
    area_cnt  = '0;
  endtask

  // classify one pixel, advance the run tracker, return the marked pixel
  function automatic marked_pixel_t track_pixel(pixel_t p);
    marked_pixel_t res;
    bit            hit;
    logic [RUN_W-1:0] width_now;
    hit = in_window(int'(p.red), int'(p.green), int'(p.blue));
    width_now = {1'b0, col} + 1'b1;
    res = '0;
    res.blue  = p.blue >> 1;
    res.green = p.green >> 1;
    res.red   = hit ? 8'd255 : (p.red >> 1);
    res.hit   = hit;
    res.done  = p.frame_end;

    if (hit) begin
      if (area_cnt != '1) area_cnt = area_cnt + 1'b1;
      if (run_len == '0) run_beg = col;
      if (run_len != '1) run_len = run_len + 1'b1;
    end else begin
      // close the open run
      if (run_len > best_len) begin
        best_mid = run_beg + ((col - run_beg) >> 1);
        best_len = run_len;
      end
      run_len = '0;
    end

    // drop an open run at the end of a row
    if (p.row_end || p.frame_end) begin
      run_len = '0;
      col = '0;
    end else if (col != '1) begin
      col = col + 1'b1;
    end

    if (p.frame_end) begin
      res.found = (area_cnt > area_gate) && (best_len > run_min);
      res.x     = best_mid;
      res.area  = area_cnt;
      res.run   = best_len;
      res.width = width_now;
      run_len  = '0;
      run_beg  = '0;
      best_len = '0;
      best_mid = '0;
      area_cnt = '0;
      col      = '0;
    end
    return res;
  endfunction

  // idle length: mostly none or short, a few long
  function automatic int pick_idle(bit steady);
    int roll;
    roll = $urandom_range(0, 99);
    if (steady || roll < 60) return 0;
    if (roll < 87) return $urandom_range(1, 3);
    if (roll < 98) return $urandom_range(4, 25);
    return $urandom_range(40, 120);
  endfunction

  function automatic int near_grey(int base);
    int v;
    v = base + int'($urandom_range(0, 40)) - 20;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return v;
  endfunction

  // random pixel; when a hit is wanted, search for one inside the windows
  function automatic pixel_t pick_pixel(bit want_hit);
    pixel_t p;
    int     base;
    p = '0;
    for (int i = 0; i < 64; i++) begin
      base = $urandom_range(0, 255);
      if ($urandom_range(0, 1) == 0) begin
        p.red   = PIX_W'($urandom_range(0, 255));
        p.green = PIX_W'($urandom_range(0, 255));
        p.blue  = PIX_W'($urandom_range(0, 255));
      end else begin
        p.red   = PIX_W'(near_grey(base));
        p.green = PIX_W'(near_grey(base));
        p.blue  = PIX_W'(near_grey(base));
      end
      if (!want_hit || in_window(int'(p.red), int'(p.green), int'(p.blue))) return p;
    end
    return p;
  endfunction

  task automatic report_mismatch(string msg);
    if (mismatches < MAX_REPORTS) $display("mismatch at %0t: %s", $time, msg);
    mismatches++;
  endtask

  task automatic check_field(string name, int got, int want);
    if (got != want) report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
  endtask

  task automatic push_item(pixel_t p);
    pixels_pending.push_back(p);
    pixels_queued++;
  endtask

  task automatic push_rgb(int r, int g, int b, bit row_end, bit frame_end);
    pixel_t p;
    p.red       = r[7:0];
    p.green     = g[7:0];
    p.blue      = b[7:0];
    p.row_end   = row_end;
    p.frame_end = frame_end;
    push_item(p);
  endtask

  // well-formed frame: small size, sticky hits so runs form
  task automatic push_frame();
    int     w;
    int     h;
    int     flip_pct;
    bit     hit;
    pixel_t p;
    w = ($urandom_range(0, 9) == 0) ? $urandom_range(16, 48) : $urandom_range(1, 8);
    h = $urandom_range(1, 5);
    flip_pct = $urandom_range(10, 50);
    hit = 1'($urandom_range(0, 1));
    for (int y = 0; y < h; y++) begin
      for (int x = 0; x < w; x++) begin
        if ($urandom_range(0, 99) < flip_pct) hit = !hit;
        p = pick_pixel(hit);
        p.row_end   = (x == w - 1);
        p.frame_end = (x == w - 1) && (y == h - 1);
        push_item(p);
      end
    end
  endtask

  // stray pixels with random row and frame markers
  task automatic push_noise(int n);
    pixel_t p;
    for (int i = 0; i < n; i++) begin
      p = pick_pixel(1'b0);
      p.row_end   = ($urandom_range(0, 7) == 0);
      p.frame_end = ($urandom_range(0, 15) == 0);
      push_item(p);
    end
  endtask

  // wait until every request is taken and every result checked
  task automatic drain();
    while (!(pixels_taken == pixels_queued && marks_due.size() == 0)) @(posedge clk);
  endtask

  task automatic set_reg(logic [CFG_IDX_W-1:0] idx, int value);
    logic [CFG_DATA_W-1:0] d;
    d = value[CFG_DATA_W-1:0];
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= d;
    case (idx)
      CFG_HUE_CENTER:     hue_ctr   = int'($signed(d[WIN_W-1:0]));
      CFG_HUE_HALFWIDTH:  hue_half  = int'(d[WIN_W-1:0]);
      CFG_SAT_CENTER:     sat_ctr   = int'($signed(d[WIN_W-1:0]));
      CFG_SAT_HALFWIDTH:  sat_half  = int'(d[WIN_W-1:0]);
      CFG_AREA_THRESHOLD: area_gate = d[AREA_W-1:0];
      CFG_RUN_THRESHOLD:  run_min   = d[RUN_W-1:0];
      default: ;
    endcase
  endtask

  task automatic load_config(int hc, int hh, int sc, int sh, int area, int run);
    set_reg(CFG_HUE_CENTER, hc);
    set_reg(CFG_HUE_HALFWIDTH, hh);
    set_reg(CFG_SAT_CENTER, sc);
    set_reg(CFG_SAT_HALFWIDTH, sh);
    set_reg(CFG_AREA_THRESHOLD, area);
    set_reg(CFG_RUN_THRESHOLD, run);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic run_extreme(int hc, int hh, int sc, int sh, int area, int run);
    load_config(hc, hh, sc, sh, area, run);
    push_frame();
    push_noise(4);
    drain();
  endtask

  task automatic random_phase(int k);
    int start;
    int n;
    sender_steady   = ($urandom_range(0, 3) == 0);
    receiver_steady = ($urandom_range(0, 3) == 0);
    if ($urandom_range(0, 2) == 0) begin
      load_config(int'($urandom_range(0, 360)) - 180, $urandom_range(0, 360),
                  int'($urandom_range(0, 510)) - 255, $urandom_range(0, 510),
                  $urandom_range(0, 1048576), $urandom_range(0, 1024));
    end else begin
      load_config(int'($urandom_range(0, 360)) - 180, $urandom_range(10, 90),
                  int'($urandom_range(0, 510)) - 255, $urandom_range(30, 300),
                  $urandom_range(0, 30), $urandom_range(0, 6));
    end
    start = pixels_queued;
    n = $urandom_range(60, 90);
    while (pixels_queued - start < n) begin
      // hold the sender until everything already sent has come back
      if (k == 2 && pixels_queued - start >= n / 2 && pixels_queued - start < n / 2 + 10) begin
        drain();
        start = start - 10;
      end
      if ($urandom_range(0, 6) == 0) push_noise($urandom_range(1, 6));
      else push_frame();
    end
    // stall the result side long enough to back up the input
    if (k == 1) hold_asks++;
    drain();
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // request driver
  always @(negedge clk) begin : pixel_driver
    pixel_t nxt;
    if (rst_n && (!in_if.valid || pix_taken)) begin
      if (send_gap > 0) begin
        in_if.valid <= 1'b0;
        send_gap--;
      end else if (pixels_pending.size() > 0) begin
        nxt = pixels_pending.pop_front();
        in_if.pix_red   <= nxt.red;
        in_if.pix_green <= nxt.green;
        in_if.pix_blue  <= nxt.blue;
        in_if.row_end   <= nxt.row_end;
        in_if.frame_end <= nxt.frame_end;
        in_if.valid     <= 1'b1;
        send_gap = pick_idle(sender_steady);
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // result ready with random stalls and a requested long hold-off
  always @(negedge clk) begin : result_ready
    if (hold_asks != hold_served) begin
      hold_left = HOLD_OFF_CYCLES;
      hold_served++;
    end
    if (hold_left > 0) begin
      out_if.ready <= 1'b0;
      hold_left--;
    end else if (stall_left > 0) begin
      out_if.ready <= 1'b0;
      stall_left--;
    end else begin
      out_if.ready <= 1'b1;
      stall_left = pick_idle(receiver_steady);
    end
  end

  // predict on accepted pixels, check accepted results
  always @(posedge clk) begin : result_monitor
    marked_pixel_t want;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      pix_taken = rst_n && in_if.valid && in_if.ready;
      if (pix_taken) begin
        marks_due.push_back(track_pixel({in_if.pix_red, in_if.pix_green, in_if.pix_blue,
                                         in_if.row_end, in_if.frame_end}));
        pixels_taken++;
      end
      if (rst_n && out_if.valid && out_if.ready) begin
        if (marks_due.size() == 0) begin
          report_mismatch("result with no pixel pending");
        end else begin
          want = marks_due.pop_front();
          check_field("out_blue", out_if.out_blue, want.blue);
          check_field("out_green", out_if.out_green, want.green);
          check_field("out_red", out_if.out_red, want.red);
          check_field("is_match", out_if.is_match, want.hit);
          check_field("frame_done", out_if.frame_done, want.done);
          check_field("ball_found", out_if.ball_found, want.found);
          check_field("ball_x", out_if.ball_x, want.x);
          check_field("match_area", out_if.match_area, want.area);
          check_field("longest_run", out_if.longest_run, want.run);
          check_field("row_width", out_if.row_width, want.width);
        end
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_if.valid = 1'b0;
    in_if.pix_red = '0;
    in_if.pix_green = '0;
    in_if.pix_blue = '0;
    in_if.row_end = 1'b0;
    in_if.frame_end = 1'b0;
    out_if.ready = 1'b0;
    pixels_queued = 0;
    pixels_taken = 0;
    mismatches = 0;
    cycles = 0;
    pix_taken = 1'b0;
    sender_steady = 1'b0;
    receiver_steady = 1'b0;
    send_gap = 0;
    stall_left = 0;
    hold_left = 0;
    hold_asks = 0;
    hold_served = 0;
    reset_tracker_model();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // default windows: extremes, channel ties, negative and truncated hues
    push_rgb(0, 0, 0, 0, 0);
    push_rgb(255, 255, 255, 0, 0);
    push_rgb(255, 0, 0, 0, 0);
    push_rgb(0, 255, 0, 0, 0);
    push_rgb(0, 0, 255, 0, 0);
    push_rgb(255, 255, 0, 0, 0);
    push_rgb(0, 255, 255, 0, 0);
    push_rgb(255, 0, 255, 0, 0);
    push_rgb(200, 101, 150, 0, 0);
    push_rgb(10, 20, 200, 0, 0);
    push_rgb(1, 0, 0, 1, 0);
    // run closed by a miss, then a run left open at the row end
    push_rgb(128, 128, 128, 0, 0);
    push_rgb(128, 128, 128, 0, 0);
    push_rgb(128, 128, 128, 0, 0);
    push_rgb(255, 0, 0, 0, 0);
    push_rgb(128, 128, 128, 0, 0);
    push_rgb(128, 128, 128, 1, 0);
    // frame end together with row end, on a hit
    push_rgb(255, 0, 0, 0, 0);
    push_rgb(128, 128, 128, 0, 0);
    push_rgb(128, 128, 128, 0, 0);
    push_rgb(255, 0, 0, 0, 0);
    push_rgb(128, 128, 128, 1, 1);
    // single-pixel frame, frame end without row end
    push_rgb(128, 128, 128, 0, 1);
    drain();

    // window and threshold extremes
    run_extreme(0, 360, 0, 510, 0, 0);
    run_extreme(-180, 0, -255, 0, 1048576, 1024);
    run_extreme(180, 360, 255, 510, 1048576, 0);
    run_extreme(-180, 360, -255, 510, 0, 1024);

    // long matching row closed by a miss, then a short run cut by frame end
    sender_steady = 1'b1;
    receiver_steady = 1'b1;
    load_config(0, 360, 0, 255, 0, 1024);
    for (int i = 0; i < LONG_ROW_PIXELS; i++) push_rgb(128, 128, 128, 0, 0);
    push_rgb(255, 0, 0, 0, 0);
    push_rgb(128, 128, 128, 1, 0);
    push_rgb(128, 128, 128, 0, 0);
    push_rgb(255, 0, 0, 1, 1);
    drain();

    begin : random_part
      int start;
      int k;
      start = pixels_queued;
      k = 0;
      while (pixels_queued - start < RANDOM_ITEMS) begin
        random_phase(k);
        k++;
      end
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

>>> color_blob_run_tracker.f
rtl/core/cbrt_pkg.sv
rtl/core/cbrt_if.sv
rtl/core/cbrt_div.sv
rtl/core/cbrt_front.sv
rtl/core/cbrt_queue.sv
rtl/core/cbrt_back.sv
rtl/core/color_blob_run_tracker.sv
tb/tb.sv
